>>> hdl/shs_pkg.sv
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
// Used by shs_sched, shs_round and sha256_byte_stream_hasher; depends on nothing.
package shs_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ROUNDS   = 64;
    localparam int unsigned ROUND_W  = $clog2(ROUNDS);
    localparam int unsigned SCHED_N  = 16;
    localparam int unsigned HASH_N   = 8;
    localparam int unsigned HIDX_W   = $clog2(HASH_N);
    localparam int unsigned FILL_W   = 6;

    localparam logic [BYTE_W-1:0] PAD_MARKER  = 8'h80;
    localparam logic [FILL_W-1:0] PAD_LEN_POS = 6'd56;

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word K_ROUND [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word H_INIT [HASH_N] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Controls from the sequencer to the message schedule.
    typedef struct packed {
        logic              push;      // take one byte
        logic [BYTE_W-1:0] data;      // byte to take
        logic              word_end;  // byte closes a 32-bit word
        logic              step;      // advance the schedule one round
    } t_sched_ctl;

    // Controls from the sequencer to the round unit.
    typedef struct packed {
        logic               load;     // copy hash words into working vars
        logic               step;     // run one compression round
        logic               finish;   // add working vars into hash words
        logic               init;     // return hash words to initial values
        logic [ROUND_W-1:0] round;    // round number for the constant
    } t_round_ctl;

    function automatic t_word small_sigma0(input t_word x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

endpackage

>>> hdl/shs_sched.sv
// Message schedule: packs bytes into words and holds the 16-word window.
// Depends on shs_pkg.
module shs_sched (
    input  logic                i_clk,
    input  shs_pkg::t_sched_ctl i_ctl,
    output shs_pkg::t_word      o_w
);
    import shs_pkg::*;

    logic [3*BYTE_W-1:0] r_acc;
    t_word               r_win [SCHED_N];
    t_word               new_w;
    t_word               in_word;

    assign in_word = {r_acc, i_ctl.data};
    assign new_w   = r_win[0] + small_sigma0(r_win[1]) + r_win[9] + small_sigma1(r_win[14]);
    assign o_w     = r_win[0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !i_ctl.word_end) begin
            r_acc <= {r_acc[2*BYTE_W-1:0], i_ctl.data};
        end
    end

    // Shift in a finished word while loading, or the expanded word per round.
    always_ff @(posedge i_clk) begin
        if ((i_ctl.push && i_ctl.word_end) || i_ctl.step) begin
            for (int i = 0; i < SCHED_N - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[SCHED_N-1] <= i_ctl.step ? new_w : in_word;
        end
    end

endmodule

>>> hdl/shs_round.sv
// Compression round unit: working variables, one round per step, hash feed-forward.
// Depends on shs_pkg.
module shs_round (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  shs_pkg::t_round_ctl         i_ctl,
    input  shs_pkg::t_word              i_w,
    input  logic [shs_pkg::HIDX_W-1:0]  i_sel,
    output shs_pkg::t_word              o_hash
);
    import shs_pkg::*;

    t_word r_hash [HASH_N];
    t_word r_v    [HASH_N];
    t_word t1;
    t_word t2;
    t_word choose;
    t_word major;

    assign choose = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign major  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1     = r_v[7] + big_sigma1(r_v[4]) + choose + K_ROUND[i_ctl.round] + i_w;
    assign t2     = big_sigma0(r_v[0]) + major;
    assign o_hash = r_hash[i_sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            r_hash <= H_INIT;
        end else if (i_ctl.finish) begin
            for (int i = 0; i < HASH_N; i++) begin
                r_hash[i] <= r_hash[i] + r_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_v <= r_hash;
        end else if (i_ctl.step) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

endmodule

>>> hdl/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher top level; uses shs_pkg, shs_sched and shs_round.
// Input: a byte item is taken every cycle while a block fills; the item completing a 64-byte
// block holds stall high while compressing (64 rounds on one shared unit, one feed-forward).
// End of message: 9 to 72 padding bytes, one a cycle except while a block compresses or
// the zeros reach the length field; one or two compressions, then eight digest words,
// one per unstalled cycle. Reset (sync, active low): initial hash, counts clear.
module sha256_byte_stream_hasher (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input item channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [shs_pkg::BYTE_W-1:0]  i_msg_byte,
    input  logic                        i_byte_present,
    input  logic                        i_end_of_message,
    // digest word channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [shs_pkg::WORD_W-1:0]  o_digest_word,
    output logic [shs_pkg::HIDX_W-1:0]  o_word_index,
    output logic                        o_last_word
);
    import shs_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;  // take input items
    localparam logic [2:0] S_ROUND = 3'd1;  // 64 compression rounds
    localparam logic [2:0] S_FINAL = 3'd2;  // add working vars into hash
    localparam logic [2:0] S_PAD   = 3'd3;  // push padding bytes
    localparam logic [2:0] S_OUT   = 3'd4;  // hand out digest words

    // Padding phases
    localparam logic [1:0] P_MARK = 2'd0;   // marker byte
    localparam logic [1:0] P_ZERO = 2'd1;   // zeros up to the length field
    localparam logic [1:0] P_LEN  = 2'd2;   // eight length bytes
    localparam logic [1:0] P_DONE = 2'd3;   // last block is compressing

    localparam logic [FILL_W-1:0]  FILL_LAST  = '1;
    localparam logic [ROUND_W-1:0] ROUND_LAST = '1;
    localparam logic [HIDX_W-1:0]  WORD_LAST  = '1;
    localparam logic [63:0]        BITS_STEP  = 64'd8;

    logic [2:0]         r_state,   n_state;
    logic [1:0]         r_pstage,  n_pstage;
    logic               r_padding, n_padding;
    logic [FILL_W-1:0]  r_fill,    n_fill;
    logic [63:0]        r_bits,    n_bits;
    logic [ROUND_W-1:0] r_round,   n_round;
    logic [HIDX_W-1:0]  r_out_idx, n_out_idx;

    logic               in_acc;
    logic               out_acc;
    logic               push;
    logic [BYTE_W-1:0]  push_data;
    logic               block_full;
    logic [BYTE_W-1:0]  len_byte;

    t_sched_ctl         sched_ctl;
    t_round_ctl         round_ctl;
    t_word              sched_w;
    t_word              hash_word;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    // Length field goes out big-endian: byte k of the field is bits 63-8k down.
    assign len_byte = r_bits[{~r_fill[2:0], 3'b000} +: BYTE_W];

    // Pick the byte that enters the block this cycle, from the port or the padder.
    always_comb begin
        push      = 1'b0;
        push_data = '0;
        case (r_state)
            S_IDLE: begin
                push      = in_acc && i_byte_present;
                push_data = i_msg_byte;
            end
            S_PAD: begin
                case (r_pstage)
                    P_MARK: begin
                        push      = 1'b1;
                        push_data = PAD_MARKER;
                    end
                    P_ZERO: begin
                        push      = (r_fill != PAD_LEN_POS);
                    end
                    P_LEN: begin
                        push      = 1'b1;
                        push_data = len_byte;
                    end
                    default: begin
                        push      = 1'b0;
                    end
                endcase
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    assign block_full = push && (r_fill == FILL_LAST);

    always_comb begin
        n_state   = r_state;
        n_pstage  = r_pstage;
        n_padding = r_padding;
        n_fill    = push ? r_fill + 1'b1 : r_fill;
        n_bits    = r_bits;
        n_round   = r_round;
        n_out_idx = r_out_idx;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_byte_present) begin
                        n_bits = r_bits + BITS_STEP;
                    end
                    if (i_end_of_message) begin
                        n_padding = 1'b1;
                        n_pstage  = P_MARK;
                        n_state   = S_PAD;
                    end
                    // a full block compresses first, padding follows
                    if (block_full) begin
                        n_state = S_ROUND;
                    end
                end
            end
            S_ROUND: begin
                n_round = r_round + 1'b1;
                if (r_round == ROUND_LAST) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (!r_padding) begin
                    n_state = S_IDLE;
                end else if (r_pstage == P_DONE) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_PAD: begin
                case (r_pstage)
                    P_MARK: n_pstage = P_ZERO;
                    P_ZERO: begin
                        if (r_fill == PAD_LEN_POS) begin
                            n_pstage = P_LEN;
                        end
                    end
                    P_LEN: begin
                        if (r_fill == FILL_LAST) begin
                            n_pstage = P_DONE;
                        end
                    end
                    default: n_pstage = r_pstage;
                endcase
                if (block_full) begin
                    n_state = S_ROUND;
                end
            end
            S_OUT: begin
                if (out_acc) begin
                    n_out_idx = r_out_idx + 1'b1;
                    if (r_out_idx == WORD_LAST) begin
                        // drop the message state, ready for the next one
                        n_state   = S_IDLE;
                        n_padding = 1'b0;
                        n_bits    = '0;
                        n_fill    = '0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pstage  <= P_MARK;
            r_padding <= 1'b0;
            r_fill    <= '0;
            r_bits    <= '0;
            r_round   <= '0;
            r_out_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_pstage  <= n_pstage;
            r_padding <= n_padding;
            r_fill    <= n_fill;
            r_bits    <= n_bits;
            r_round   <= n_round;
            r_out_idx <= n_out_idx;
        end
    end

    assign sched_ctl.push     = push;
    assign sched_ctl.data     = push_data;
    assign sched_ctl.word_end = (r_fill[1:0] == 2'b11);
    assign sched_ctl.step     = (r_state == S_ROUND);

    assign round_ctl.load     = block_full;
    assign round_ctl.step     = (r_state == S_ROUND);
    assign round_ctl.finish   = (r_state == S_FINAL);
    assign round_ctl.init     = out_acc && (r_out_idx == WORD_LAST);
    assign round_ctl.round    = r_round;

    shs_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (sched_ctl),
        .o_w   (sched_w)
    );

    shs_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (round_ctl),
        .i_w     (sched_w),
        .i_sel   (r_out_idx),
        .o_hash  (hash_word)
    );

    assign o_digest_word = hash_word;
    assign o_word_index  = r_out_idx;
    assign o_last_word   = (r_out_idx == WORD_LAST);

    // The feed-forward add follows only the last of 64 rounds.
    a_final_after_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL) |-> ($past(r_state) == S_ROUND && $past(r_round) == ROUND_LAST))
        else $error("feed-forward without a full round sequence");

    // The length bytes never come before byte 56 of a block.
    a_len_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAD && r_pstage == P_LEN) |-> (r_fill >= PAD_LEN_POS))
        else $error("length bytes outside the length field");

    // Digest words are shown only after a padded message closed its final block.
    a_out_block_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_OUT) |-> (r_fill == '0 && r_padding && r_pstage == P_DONE))
        else $error("digest shown before the final block");

    // After the last digest word, the block is back to an empty message.
    a_clear_after_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last_word) |=> (r_state == S_IDLE && r_bits == '0 && !r_padding))
        else $error("message state not cleared after digest");

endmodule
